/* hdl/histogram_median_filter_assert.svh */
`ifndef HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH
`define HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define HMF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("histogram median filter: assertion failed");

// Next-cycle implication
`define HMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("histogram median filter: assertion failed");

`endif

/* hdl/hmf_pkg.sv */
`timescale 1ns / 1ps

package hmf_pkg;

	localparam int PIX_W    = 8;
	localparam int LEVELS   = 256;
	localparam int GRP_W    = 4;
	localparam int FINE_W   = 4;
	localparam int CFG_W    = 11;
	localparam int RAD_CFG_W = 2;
	localparam int POS_W    = 11;
	localparam int OUT_POS_W = 10;
	localparam int IDX_CFG_W = 2;

	// configuration register indexes
	localparam logic [IDX_CFG_W-1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [IDX_CFG_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_CFG_W-1:0] REG_RADIUS       = 2'd2;

	localparam logic [CFG_W-1:0]     RST_LINE_WIDTH   = 11'd640;
	localparam logic [CFG_W-1:0]     RST_FRAME_HEIGHT = 11'd480;
	localparam logic [RAD_CFG_W-1:0] RST_RADIUS       = 2'd1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             start_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]     median;
		logic [OUT_POS_W-1:0] center_row;
		logic [OUT_POS_W-1:0] center_col;
		logic                 last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_HRD,
		ST_HWR,
		ST_CSCAN,
		ST_FRD,
		ST_FCHK,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load;
		logic hist_rd;
		logic hist_wr;
		logic scan_init;
		logic cscan;
		logic fine_rd;
		logic fine_chk;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic interior;
		logic ops_last;
		logic grp_found;
		logic med_found;
		logic out_free;
	} sts_t;

endpackage

/* hdl/histogram_median_filter.sv */
`timescale 1ns / 1ps
// Running-histogram median filter over a (2r+1)x(2r+1) square, 8-bit pixels.
// Input channel in_valid/in_ready/in_data carries pixels in raster order;
// start_of_frame restarts the frame and takes the configuration in.
// Output channel out_valid/out_ready/out_data gives one median per interior
// pixel with its center position; last marks the final one of the frame.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data is always ready;
// writes take effect at the next frame start or frame wrap.
// Steps per pixel, set by the histogram RAM (one write, one registered read
//   port) and its sequencer: a border pixel is accepted and loaded only.
//   An interior pixel then gets a read and a write per bin update, for 2*side
//   updates on a slide or side*side on a row start rebuild, then a group scan,
//   a bin scan and the output load; side = 2r+1. The result is then registered onto out_valid.
// One pixel is in work at a time. A waiting result sits in the output register
// while the next pixel is taken; only a second result waits for out_ready.
// Reset clears positions, histogram valid bits and group counts and restores
// line_width 640, frame_height 480, radius 1. Line store needs no clearing.

module histogram_median_filter import hmf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_CFG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	`include "histogram_median_filter_assert.svh"

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	hmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hmf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// checks
	`HMF_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
	`HMF_ASSERT_NOW(a_out_slot, cmd.out_load, !out_valid || out_ready)
	`HMF_ASSERT_NOW(a_rmw_order, cmd.hist_wr, $past(cmd.hist_rd))

endmodule

/* hdl/hmf_ram.sv */
`timescale 1ns / 1ps

module hmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/hmf_ctrl.sv */
`timescale 1ns / 1ps

module hmf_ctrl import hmf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = sts.interior ? ST_HRD : ST_IDLE;
			end
			ST_HRD: begin
				cmd.hist_rd = 1'b1;
				state_d     = ST_HWR;
			end
			ST_HWR: begin
				cmd.hist_wr = 1'b1;
				if (sts.ops_last) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_CSCAN;
				end else begin
					state_d = ST_HRD;
				end
			end
			ST_CSCAN: begin
				cmd.cscan = 1'b1;
				if (sts.grp_found) begin
					state_d = ST_FRD;
				end
			end
			ST_FRD: begin
				cmd.fine_rd = 1'b1;
				state_d     = ST_FCHK;
			end
			ST_FCHK: begin
				cmd.fine_chk = 1'b1;
				state_d      = sts.med_found ? ST_OUT : ST_FRD;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/hmf_datapath.sv */
`timescale 1ns / 1ps

module hmf_datapath import hmf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_data,
	input  logic                 cfg_we,
	input  logic [IDX_CFG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
	localparam int LS_N     = 2 * MAX_RADIUS;
	localparam int LS_W     = PIX_W * LS_N;
	localparam int AW       = $clog2(MAX_WIDTH);
	localparam int CNT_W    = $clog2(SIDE_MAX * SIDE_MAX + 1);
	localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
	localparam int IDX_W    = $clog2(SIDE_MAX);
	localparam int HAW      = $clog2(LEVELS);

	// configuration registers and working copies
	logic [CFG_W-1:0]     cfg_width_q, cfg_height_q;
	logic [RAD_CFG_W-1:0] cfg_radius_q;
	logic [CFG_W-1:0]     cur_width_q, cur_height_q;
	logic [RAD_W-1:0]     cur_rad_q;
	logic [CFG_W-1:0]     lat_width, lat_height;
	logic [RAD_W-1:0]     lat_rad;

	logic [POS_W-1:0] pos_row_q, pos_col_q;
	logic [PIX_W-1:0] px_q;

	logic [PIX_W-1:0] win_q  [SIDE_MAX][SIDE_MAX];
	logic [PIX_W-1:0] drop_q [SIDE_MAX];
	logic [PIX_W-1:0] drop_sel [SIDE_MAX];
	logic [PIX_W-1:0] vec    [SIDE_MAX];
	logic [PIX_W-1:0] ls_byte [LS_N];
	logic [PIX_W-1:0] ls_wbyte [LS_N];
	logic [LS_W-1:0]  ls_rdata, ls_wdata;
	logic [AW-1:0]    ls_raddr;
	int               two_r;

	// per item
	logic [RAD_W-1:0]     rad_q;
	logic [CNT_W-1:0]     need_q;
	logic [OUT_POS_W-1:0] res_row_q, res_col_q;
	logic                 res_last_q;
	logic [POS_W-1:0]     ctr_row, ctr_col;
	logic [POS_W:0]       nxt_col, nxt_row;
	logic                 rebuild;

	// histogram update sequencer
	logic             drop_ph_q;
	logic [IDX_W-1:0] op_a_q, op_k_q, alim_q;
	logic [PIX_W-1:0] hval;
	logic             ops_last;

	// histogram storage
	logic [LEVELS-1:0] vld_q;
	logic [CNT_W-1:0]  coarse_q [1 << GRP_W];
	logic [CNT_W-1:0]  h_rdata, h_cnt, h_new;
	logic [HAW-1:0]    h_raddr;

	// median search
	logic [CNT_W-1:0]  csum_q;
	logic [GRP_W-1:0]  g_q;
	logic [FINE_W-1:0] j_q;
	logic [CNT_W:0]    c_sum, f_sum;
	logic [CNT_W-1:0]  f_cnt;
	logic              grp_found, med_found;
	logic [PIX_W-1:0]  med_q;

	logic      out_valid_q;
	out_item_t out_data_q;

	// clamped configuration, copied at frame start and frame wrap
	always_comb begin
		lat_width = cfg_width_q;
		if (cfg_width_q == '0) begin
			lat_width = CFG_W'(1);
		end else if (int'(cfg_width_q) > MAX_WIDTH) begin
			lat_width = CFG_W'(MAX_WIDTH);
		end
		lat_height = cfg_height_q;
		if (cfg_height_q == '0) begin
			lat_height = CFG_W'(1);
		end else if (int'(cfg_height_q) > MAX_HEIGHT) begin
			lat_height = CFG_W'(MAX_HEIGHT);
		end
		if (int'(cfg_radius_q) > MAX_RADIUS) begin
			lat_rad = RAD_W'(MAX_RADIUS);
		end else begin
			lat_rad = RAD_W'(cfg_radius_q);
		end
	end

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= RST_LINE_WIDTH;
			cfg_height_q <= RST_FRAME_HEIGHT;
			cfg_radius_q <= RST_RADIUS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_WIDTH:   cfg_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: cfg_height_q <= cfg_data;
				REG_RADIUS:       cfg_radius_q <= cfg_data[RAD_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// line store: one word per column holds the 2r older rows
	assign ls_raddr = in_data.start_of_frame ? '0 : AW'(pos_col_q);

	hmf_ram #(.WIDTH(LS_W), .DEPTH(MAX_WIDTH)) u_line_ram (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (AW'(pos_col_q)),
		.wdata (ls_wdata),
		.re    (cmd.accept),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	// column vector, line store update and outgoing column
	always_comb begin
		two_r = 2 * int'(cur_rad_q);
		for (int k = 0; k < LS_N; k++) begin
			ls_byte[k] = ls_rdata[PIX_W*k +: PIX_W];
		end
		for (int k = 0; k < SIDE_MAX; k++) begin
			vec[k] = px_q;
		end
		for (int k = 0; k < LS_N; k++) begin
			if (k < two_r) begin
				vec[k] = ls_byte[k];
			end
		end
		for (int k = 0; k < LS_N; k++) begin
			ls_wbyte[k] = (k < two_r) ? vec[k+1] : ls_byte[k];
			ls_wdata[PIX_W*k +: PIX_W] = ls_wbyte[k];
		end
		drop_sel = win_q[0];
		for (int a = 0; a < SIDE_MAX; a++) begin
			if (a == two_r) begin
				drop_sel = win_q[a];
			end
		end
	end

	// item position and interior test
	always_comb begin
		ctr_row = pos_row_q - POS_W'(cur_rad_q);
		ctr_col = pos_col_q - POS_W'(cur_rad_q);
		nxt_col = {1'b0, pos_col_q} + 1'b1;
		nxt_row = {1'b0, pos_row_q} + 1'b1;
		rebuild = (int'(pos_col_q) == two_r);
		sts.interior = (int'(pos_row_q) >= two_r) && (int'(pos_col_q) >= two_r);
	end

	// position counters and working configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q    <= '0;
			pos_col_q    <= '0;
			cur_width_q  <= RST_LINE_WIDTH;
			cur_height_q <= RST_FRAME_HEIGHT;
			cur_rad_q    <= RAD_W'(RST_RADIUS);
		end else if (cmd.accept) begin
			if (in_data.start_of_frame) begin
				pos_row_q    <= '0;
				pos_col_q    <= '0;
				cur_width_q  <= lat_width;
				cur_height_q <= lat_height;
				cur_rad_q    <= lat_rad;
			end
		end else if (cmd.load) begin
			if (nxt_col >= {1'b0, cur_width_q}) begin
				pos_col_q <= '0;
				if (nxt_row >= {1'b0, cur_height_q}) begin
					pos_row_q    <= '0;
					cur_width_q  <= lat_width;
					cur_height_q <= lat_height;
					cur_rad_q    <= lat_rad;
				end else begin
					pos_row_q <= nxt_row[POS_W-1:0];
				end
			end else begin
				pos_col_q <= nxt_col[POS_W-1:0];
			end
		end
	end

	// pixel, window shift and item snapshot
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= in_data.pixel;
		end
		if (cmd.load) begin
			for (int a = 0; a < SIDE_MAX; a++) begin
				if (a == 0) begin
					win_q[a] <= vec;
				end else if (a <= two_r) begin
					win_q[a] <= win_q[a-1];
				end
			end
			drop_q     <= drop_sel;
			rad_q      <= cur_rad_q;
			need_q     <= CNT_W'(two_r * (int'(cur_rad_q) + 1) + 1);
			res_row_q  <= ctr_row[OUT_POS_W-1:0];
			res_col_q  <= ctr_col[OUT_POS_W-1:0];
			res_last_q <= (pos_row_q == cur_height_q - 1'b1)
				&& (pos_col_q == cur_width_q - 1'b1);
		end
	end

	// bin value under update and end of the op list
	always_comb begin
		hval = drop_ph_q ? drop_q[op_k_q] : win_q[op_a_q][op_k_q];
		ops_last = !drop_ph_q && (int'(op_k_q) == 2 * int'(rad_q)) && (op_a_q == alim_q);
		sts.ops_last = ops_last;
	end

	// update sequencer: drop column then new column, or whole window on rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_ph_q <= 1'b0;
			op_a_q    <= '0;
			op_k_q    <= '0;
			alim_q    <= '0;
		end else if (cmd.load) begin
			drop_ph_q <= !rebuild;
			op_a_q    <= '0;
			op_k_q    <= '0;
			alim_q    <= rebuild ? IDX_W'(two_r) : '0;
		end else if (cmd.hist_wr) begin
			if (int'(op_k_q) == 2 * int'(rad_q)) begin
				op_k_q <= '0;
				if (drop_ph_q) begin
					drop_ph_q <= 1'b0;
				end else if (op_a_q != alim_q) begin
					op_a_q <= op_a_q + 1'b1;
				end
			end else begin
				op_k_q <= op_k_q + 1'b1;
			end
		end
	end

	// fine bin counts
	assign h_raddr = cmd.fine_rd ? {g_q, j_q} : hval;

	hmf_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_hist_ram (
		.clk   (clk),
		.we    (cmd.hist_wr),
		.waddr (hval),
		.wdata (h_new),
		.re    (cmd.hist_rd || cmd.fine_rd),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	always_comb begin
		h_cnt = vld_q[hval] ? h_rdata : '0;
		h_new = drop_ph_q ? (h_cnt - 1'b1) : (h_cnt + 1'b1);
	end

	// valid bits and group counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int g = 0; g < (1 << GRP_W); g++) begin
				coarse_q[g] <= '0;
			end
		end else if (cmd.load && sts.interior && rebuild) begin
			vld_q <= '0;
			for (int g = 0; g < (1 << GRP_W); g++) begin
				coarse_q[g] <= '0;
			end
		end else if (cmd.hist_wr) begin
			vld_q[hval] <= 1'b1;
			if (drop_ph_q) begin
				coarse_q[hval[PIX_W-1 -: GRP_W]] <= coarse_q[hval[PIX_W-1 -: GRP_W]] - 1'b1;
			end else begin
				coarse_q[hval[PIX_W-1 -: GRP_W]] <= coarse_q[hval[PIX_W-1 -: GRP_W]] + 1'b1;
			end
		end
	end

	// median search: group counts first, then bins of the chosen group
	always_comb begin
		c_sum = {1'b0, csum_q} + {1'b0, coarse_q[g_q]};
		grp_found = (c_sum >= {1'b0, need_q}) || (g_q == '1);
		f_cnt = vld_q[{g_q, j_q}] ? h_rdata : '0;
		f_sum = {1'b0, csum_q} + {1'b0, f_cnt};
		med_found = (f_sum >= {1'b0, need_q}) || (j_q == '1);
		sts.grp_found = grp_found;
		sts.med_found = med_found;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			csum_q <= '0;
			g_q    <= '0;
			j_q    <= '0;
		end else if (cmd.cscan && !grp_found) begin
			csum_q <= c_sum[CNT_W-1:0];
			g_q    <= g_q + 1'b1;
		end else if (cmd.fine_chk) begin
			if (med_found) begin
				med_q <= {g_q, j_q};
			end else begin
				csum_q <= f_sum[CNT_W-1:0];
				j_q    <= j_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.median     <= med_q;
			out_data_q.center_row <= res_row_q;
			out_data_q.center_col <= res_col_q;
			out_data_q.last       <= res_last_q;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

endmodule
